/* rtl/core/seconds_to_calendar_defines.svh */
// Assertion macros shared by the calendar converter RTL.
`ifndef SECONDS_TO_CALENDAR_DEFINES_SVH
`define SECONDS_TO_CALENDAR_DEFINES_SVH

// Check that a condition holds on every clock edge out of reset.
`define S2C_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check that a trigger implies a consequence on the same edge.
`define S2C_ASSERT_SAME(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// Check that a trigger implies a consequence on the next edge.
`define S2C_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/s2c_pkg.sv */
// Shared constants, types and tables of the calendar converter.
package s2c_pkg;

   // Seconds bits in use; the port carries at most 32 of them
   localparam int SECONDS_WIDTH = 32;
   localparam int IN_WIDTH      = (SECONDS_WIDTH < 32) ? SECONDS_WIDTH : 32;

   // Serial divider geometry
   localparam int DIV_W  = IN_WIDTH;
   localparam int REM_W  = 17;
   localparam int CNT_W  = $clog2(DIV_W + 1);

   // Quotient widths: 86400 exceeds 2^16, 1461 exceeds 2^10
   localparam int DAYS_W  = IN_WIDTH - 16;
   localparam int CYCLE_W = (IN_WIDTH > 27) ? (IN_WIDTH - 26) : 1;
   localparam int MIN_BITS = 12;
   localparam int DOY_W   = 11;

   localparam logic [REM_W-1:0] SEC_PER_DAY  = REM_W'(86400);
   localparam logic [REM_W-1:0] SEC_PER_HOUR = REM_W'(3600);
   localparam logic [REM_W-1:0] SEC_PER_MIN  = REM_W'(60);
   localparam logic [REM_W-1:0] DAYS_PER_CYCLE = REM_W'(1461);
   localparam logic [DOY_W-1:0] DAYS_LEAP_YEAR = DOY_W'(366);
   localparam logic [DOY_W-1:0] DAYS_YEAR      = DOY_W'(365);
   localparam logic [3:0]       MONTH_DEC      = 4'd11;
   localparam logic [3:0]       MONTH_FEB      = 4'd1;

   // Command to the serial divider
   typedef struct packed {
      logic             start;
      logic [REM_W-1:0] divisor;
      logic [CNT_W-1:0] steps;
   } div_cmd_type;

   // Result from the serial divider
   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [REM_W-1:0] remainder;
   } div_res_type;

   // Days in a month, index 0 is January
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* rtl/core/s2c_serial_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module s2c_serial_div import s2c_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  div_cmd_type      cmd,
   input  logic [DIV_W-1:0] dividend,
   output div_res_type      res
);

   logic [DIV_W-1:0] num_ff, num_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] div_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [REM_W:0]   trial;
   logic             fits;

   // Trial subtract of the next dividend bit
   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         num_in = dividend;
         rem_in = '0;
         cnt_in = cmd.steps;
      end else if (cnt_ff != '0) begin
         num_in = {num_ff[DIV_W-2:0], fits};
         rem_in = fits ? REM_W'(trial - {1'b0, div_ff}) : REM_W'(trial);
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // Advance one bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (cmd.start) begin
         div_ff <= cmd.divisor;
      end
   end

   assign res.done      = done_ff;
   assign res.quotient  = num_ff;
   assign res.remainder = rem_ff;

endmodule

/* rtl/core/seconds_to_calendar.sv */
// Top level: seconds since year 0 to year, month, day, hour, minute, second.
// Each beat runs the day, hour, minute and cycle divisions, then the year steps and
// the month walk, between accept and strobe.
// A new beat is taken only in idle: the single serial divider and the month walk
// hold the converter, and busy stays high until the strobe cycle.
// The strobe lasts one cycle; the receiver cannot stall.
// Reset (synchronous) returns to idle and drops any beat in flight.
`include "seconds_to_calendar_defines.svh"
module seconds_to_calendar import s2c_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_elapsed_seconds,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_year_number,
   output logic [3:0]  rsp_month_number,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour_of_day,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [5:0]  rsp_second_of_minute
);

   typedef enum logic [2:0] {
      S_IDLE, S_DAY, S_HOUR, S_MIN, S_CYCLE, S_YEAR0, S_YEAR, S_MONTH
   } state_type;

   state_type          state_ff;
   logic [DAYS_W-1:0]  days_ff;
   logic [4:0]         hour_ff;
   logic [5:0]         minute_ff;
   logic [5:0]         second_ff;
   logic [CYCLE_W-1:0] cycle_ff;
   logic [1:0]         yoff_ff;
   logic               leap_ff;
   logic [DOY_W-1:0]   d_ff;
   logic [3:0]         month_ff;
   logic               strobe_ff;
   logic [7:0]         year_out_ff;
   logic [3:0]         month_out_ff;
   logic [4:0]         day_out_ff;
   logic [4:0]         hour_out_ff;
   logic [5:0]         minute_out_ff;
   logic [5:0]         second_out_ff;

   div_cmd_type      cmd;
   div_res_type      res;
   logic [DIV_W-1:0] dividend;
   logic             accept;
   logic [4:0]       mlen;
   logic             div_phase;
   logic             date_ok;

   assign accept = start && (state_ff == S_IDLE);
   assign mlen   = month_len(month_ff, leap_ff);

   // Issue the next division as the previous one finishes
   always_comb begin
      cmd.start   = 1'b0;
      cmd.divisor = SEC_PER_DAY;
      cmd.steps   = CNT_W'(IN_WIDTH);
      dividend    = DIV_W'(req_elapsed_seconds[IN_WIDTH-1:0]);
      case (state_ff)
         S_IDLE: begin
            cmd.start = accept;
         end
         S_DAY: begin
            cmd.start   = res.done;
            cmd.divisor = SEC_PER_HOUR;
            cmd.steps   = CNT_W'(REM_W);
            dividend    = DIV_W'(res.remainder) << (DIV_W - REM_W);
         end
         S_HOUR: begin
            cmd.start   = res.done;
            cmd.divisor = SEC_PER_MIN;
            cmd.steps   = CNT_W'(MIN_BITS);
            dividend    = DIV_W'(res.remainder[MIN_BITS-1:0]) << (DIV_W - MIN_BITS);
         end
         S_MIN: begin
            cmd.start   = res.done;
            cmd.divisor = DAYS_PER_CYCLE;
            cmd.steps   = CNT_W'(DAYS_W);
            dividend    = DIV_W'(days_ff) << (DIV_W - DAYS_W);
         end
         default: begin
            cmd.start = 1'b0;
         end
      endcase
   end

   s2c_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .dividend (dividend),
      .res      (res)
   );

   // Sequence the divisions, the year split and the month walk
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_DAY;
               end
            end
            S_DAY: begin
               if (res.done) begin
                  days_ff  <= res.quotient[DAYS_W-1:0];
                  state_ff <= S_HOUR;
               end
            end
            S_HOUR: begin
               if (res.done) begin
                  hour_ff  <= res.quotient[4:0];
                  state_ff <= S_MIN;
               end
            end
            S_MIN: begin
               if (res.done) begin
                  minute_ff <= res.quotient[5:0];
                  second_ff <= res.remainder[5:0];
                  state_ff  <= S_CYCLE;
               end
            end
            S_CYCLE: begin
               if (res.done) begin
                  cycle_ff <= res.quotient[CYCLE_W-1:0];
                  d_ff     <= res.remainder[DOY_W-1:0];
                  state_ff <= S_YEAR0;
               end
            end
            S_YEAR0: begin
               // First year of the cycle is the leap year
               month_ff <= '0;
               if (d_ff < DAYS_LEAP_YEAR) begin
                  yoff_ff  <= 2'd0;
                  leap_ff  <= 1'b1;
                  state_ff <= S_MONTH;
               end else begin
                  d_ff     <= d_ff - DAYS_LEAP_YEAR;
                  yoff_ff  <= 2'd1;
                  leap_ff  <= 1'b0;
                  state_ff <= S_YEAR;
               end
            end
            S_YEAR: begin
               if (d_ff >= DAYS_YEAR) begin
                  d_ff    <= d_ff - DAYS_YEAR;
                  yoff_ff <= yoff_ff + 2'd1;
               end else begin
                  state_ff <= S_MONTH;
               end
            end
            S_MONTH: begin
               if ((month_ff == MONTH_DEC) || (d_ff < DOY_W'(mlen))) begin
                  year_out_ff   <= 8'({cycle_ff, 2'b00}) + 8'(yoff_ff);
                  month_out_ff  <= month_ff + 4'd1;
                  day_out_ff    <= d_ff[4:0] + 5'd1;
                  hour_out_ff   <= hour_ff;
                  minute_out_ff <= minute_ff;
                  second_out_ff <= second_ff;
                  strobe_ff     <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  d_ff     <= d_ff - DOY_W'(mlen);
                  month_ff <= month_ff + 4'd1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = strobe_ff;
   assign rsp_year_number      = year_out_ff;
   assign rsp_month_number     = month_out_ff;
   assign rsp_day_of_month     = day_out_ff;
   assign rsp_hour_of_day      = hour_out_ff;
   assign rsp_minute_of_hour   = minute_out_ff;
   assign rsp_second_of_minute = second_out_ff;

   // Phases that wait on the divider, and the range of the date fields
   assign div_phase = (state_ff == S_DAY) || (state_ff == S_HOUR) ||
                      (state_ff == S_MIN) || (state_ff == S_CYCLE);
   assign date_ok   = (month_out_ff != 4'd0) && (month_out_ff <= 4'd12) &&
                      (day_out_ff != 5'd0);

   // A result beat never overlaps a conversion in flight
   `S2C_ASSERT_SAME(a_strobe_idle, strobe_ff, !busy, "result strobe while busy")
   // The strobe lasts a single cycle
   `S2C_ASSERT_NEXT(a_strobe_pulse, strobe_ff, !strobe_ff, "result strobe held")
   // An accepted beat starts a conversion
   `S2C_ASSERT_NEXT(a_accept_busy, accept, busy, "accept did not raise busy")
   // The divider only finishes while a division phase waits for it
   `S2C_ASSERT_SAME(a_div_phase, res.done, div_phase, "divider done outside a division phase")
   // Month and day come out 1-based and in range
   `S2C_ASSERT_SAME(a_date_range, strobe_ff, date_ok, "month or day out of range")

endmodule

/* verif/tb_seconds_to_calendar.sv */
// Self-checking testbench for the seconds to calendar converter.
`timescale 1ns / 100ps

module tb_seconds_to_calendar import s2c_pkg::*; ();

   localparam int unsigned FEBRUARY     = 1;
   localparam int unsigned DECEMBER     = 11;
   localparam int unsigned LAST_SECOND  = 86399;
   localparam int unsigned RANDOM_BEATS = 550;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam bit [63:0]   SECONDS_MASK = (64'd2 << (IN_WIDTH - 1)) - 64'd1;

   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } calendar_type;

   // One pending request beat; drain holds it back until all results are in
   typedef struct {
      logic [31:0] secs;
      bit          drain;
   } seconds_beat_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_elapsed_seconds = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [7:0]  rsp_year_number;
   logic [3:0]  rsp_month_number;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour_of_day;
   logic [5:0]  rsp_minute_of_hour;
   logic [5:0]  rsp_second_of_minute;

   seconds_beat_type seconds_pending[$];
   calendar_type     calendar_expected[$];
   seconds_beat_type head_beat;
   int unsigned      failure_count = 0;
   int unsigned      burst_left = 1;
   int unsigned      gap_left = 0;
   int unsigned      idle_cycles = 0;
   logic             drive_next;
   calendar_type     actual_calendar;
   calendar_type     expected_calendar;

   seconds_to_calendar DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_elapsed_seconds (req_elapsed_seconds),
      .rsp_strobe          (rsp_strobe),
      .rsp_year_number     (rsp_year_number),
      .rsp_month_number    (rsp_month_number),
      .rsp_day_of_month    (rsp_day_of_month),
      .rsp_hour_of_day     (rsp_hour_of_day),
      .rsp_minute_of_hour  (rsp_minute_of_hour),
      .rsp_second_of_minute(rsp_second_of_minute)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Month length, month index 0 is January
   function automatic int unsigned month_days(input int unsigned m, input bit leap);
      int unsigned len;
      case (m)
         FEBRUARY:      len = leap ? 29 : 28;
         3, 5, 8, 10:   len = 30;
         default:       len = 31;
      endcase
      return len;
   endfunction

   // Expected calendar fields for one seconds count
   function automatic calendar_type predict_calendar(input logic [31:0] secs);
      calendar_type c;
      bit [63:0]    s;
      bit [63:0]    days;
      bit [63:0]    rem;
      bit [63:0]    cycle;
      bit [63:0]    d;
      bit [63:0]    year;
      bit           leap;
      int unsigned  m;
      s     = 64'(secs) & SECONDS_MASK;
      days  = s / 64'd86400;
      rem   = s % 64'd86400;
      cycle = days / 64'd1461;
      d     = days % 64'd1461;
      // First year of each four-year cycle is the leap one
      if (d < 64'd366) begin
         year = cycle * 64'd4;
         leap = 1'b1;
      end else begin
         d    = d - 64'd366;
         year = cycle * 64'd4 + 64'd1 + d / 64'd365;
         d    = d % 64'd365;
         leap = 1'b0;
      end
      // Walk the months, December takes what is left
      m = 0;
      while (m < DECEMBER) begin
         if (d < 64'(month_days(m, leap))) break;
         d = d - 64'(month_days(m, leap));
         m++;
      end
      c.year   = year[7:0];
      c.month  = 4'(m + 1);
      c.day    = 5'(d + 64'd1);
      c.hour   = 5'(rem / 64'd3600);
      c.minute = 6'((rem % 64'd3600) / 64'd60);
      c.second = 6'(rem % 64'd60);
      return c;
   endfunction

   // Seconds count of a calendar point; mon and dom are 0-based
   function automatic bit [63:0] calendar_seconds(input int unsigned y, input int unsigned mon,
                                                   input int unsigned dom, input int unsigned sod);
      bit [63:0]   days;
      int unsigned k;
      days = 64'(365 * y + (y + 3) / 4);
      for (k = 0; k < mon; k++) days = days + 64'(month_days(k, (y % 4) == 0));
      days = days + 64'(dom);
      return days * 64'd86400 + 64'(sod);
   endfunction

   task automatic add_beat(input bit [63:0] secs, input bit drain);
      seconds_beat_type b;
      b.secs  = secs[31:0];
      b.drain = drain;
      seconds_pending.push_back(b);
   endtask

   task automatic note_failure(input string what);
      if (failure_count < REPORT_LIMIT) $display("MISMATCH: %s", what);
      failure_count++;
   endtask

   function automatic string calendar_text(input calendar_type c);
      return $sformatf("y=%0d m=%0d d=%0d %0d:%0d:%0d",
                       c.year, c.month, c.day, c.hour, c.minute, c.second);
   endfunction

   // Driver: record accepted beats, then present the next one in bursts
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            calendar_expected.push_back(predict_calendar(req_elapsed_seconds));
         end
         if (!(start && busy)) begin
            drive_next = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (seconds_pending.size() > 0 &&
                         !(seconds_pending[0].drain && calendar_expected.size() > 0)) begin
               head_beat = seconds_pending.pop_front();
               req_elapsed_seconds <= head_beat.secs;
               drive_next = 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end
            end
            start <= drive_next;
         end
      end
   end

   // Monitor: results hold for the whole strobe cycle, sample mid-cycle
   always @(negedge clock) begin
      if (!reset && rsp_strobe) begin
         actual_calendar = '{rsp_year_number, rsp_month_number, rsp_day_of_month,
                             rsp_hour_of_day, rsp_minute_of_hour, rsp_second_of_minute};
         if (calendar_expected.size() == 0) begin
            note_failure({"unexpected result ", calendar_text(actual_calendar)});
         end else begin
            expected_calendar = calendar_expected.pop_front();
            if (actual_calendar.year   !== expected_calendar.year   ||
                actual_calendar.month  !== expected_calendar.month  ||
                actual_calendar.day    !== expected_calendar.day    ||
                actual_calendar.hour   !== expected_calendar.hour   ||
                actual_calendar.minute !== expected_calendar.minute ||
                actual_calendar.second !== expected_calendar.second) begin
               note_failure({"expected ", calendar_text(expected_calendar),
                             " actual ", calendar_text(actual_calendar)});
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
            $display("seconds_to_calendar verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned k;
      int unsigned y;
      int unsigned m;
      int unsigned len;
      int unsigned dom;
      int unsigned sod;
      int unsigned drain_at;
      bit [63:0]   secs;

      // Directed: field extremes and bit patterns
      add_beat(64'h0, 1'b0);
      add_beat(64'hFFFF_FFFF, 1'b0);
      add_beat(64'h8000_0000, 1'b0);
      add_beat(64'h7FFF_FFFF, 1'b0);
      add_beat(64'hAAAA_AAAA, 1'b0);
      add_beat(64'h5555_5555, 1'b0);
      // Directed: around the leap day and year turns
      add_beat(calendar_seconds(0, FEBRUARY, 27, 0), 1'b0);
      add_beat(calendar_seconds(0, FEBRUARY, 28, LAST_SECOND), 1'b0);
      add_beat(calendar_seconds(0, 2, 0, 0), 1'b0);
      add_beat(calendar_seconds(0, DECEMBER, 30, LAST_SECOND), 1'b0);
      add_beat(calendar_seconds(1, 0, 0, 0), 1'b0);
      add_beat(calendar_seconds(1, FEBRUARY, 27, LAST_SECOND), 1'b0);
      add_beat(calendar_seconds(1, 2, 0, 0), 1'b0);
      add_beat(calendar_seconds(3, DECEMBER, 30, LAST_SECOND), 1'b0);
      add_beat(calendar_seconds(4, 0, 0, 0), 1'b0);
      // Directed: last second of January and of April to December in a common year
      add_beat(calendar_seconds(2, 0, 30, LAST_SECOND), 1'b0);
      for (m = 3; m <= DECEMBER; m++) begin
         add_beat(calendar_seconds(2, m, month_days(m, 1'b0) - 1, LAST_SECOND), 1'b0);
      end

      // Random: mostly calendar points, often at day or month edges, the rest raw counts
      drain_at = $urandom_range(100, RANDOM_BEATS - 100);
      for (k = 0; k < RANDOM_BEATS; k++) begin
         if ($urandom_range(0, 9) < 7) begin
            y   = $urandom_range(0, 136);
            m   = $urandom_range(0, DECEMBER);
            len = month_days(m, (y % 4) == 0);
            case ($urandom_range(0, 3))
               0:       dom = 0;
               1:       dom = len - 1;
               default: dom = $urandom_range(0, len - 1);
            endcase
            case ($urandom_range(0, 3))
               0:       sod = 0;
               1:       sod = LAST_SECOND;
               default: sod = $urandom_range(0, LAST_SECOND);
            endcase
            secs = calendar_seconds(y, m, dom, sod);
            if (secs > 64'hFFFF_FFFF) secs = 64'($urandom);
         end else begin
            secs = 64'($urandom);
         end
         add_beat(secs, (k == 0) || (k == drain_at));
      end

      // Hold reset, then let the driver run the queue dry
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (seconds_pending.size() > 0 || start || calendar_expected.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (calendar_expected.size() > 0) begin
         note_failure($sformatf("%0d results never arrived", calendar_expected.size()));
      end

      if (failure_count == 0) begin
         $display("seconds_to_calendar verification clean");
      end else begin
         $display("seconds_to_calendar verification failed");
      end
      $finish;
   end

endmodule
